// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the segment intersection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/sit_pkg.sv -----
// Shared types for the segment intersection pipeline.
package sit_pkg;

  // Per-stage load enables, driven by the pipeline control in the top level.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// ----- hw/rtl/sit_front.sv -----
// Stage 1: bounding box rejection and coordinate differences.
module sit_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  sit_pkg::stage_en_t            en_i,
  input  logic signed [COORD_WIDTH-1:0] ax0_i,
  input  logic signed [COORD_WIDTH-1:0] ay0_i,
  input  logic signed [COORD_WIDTH-1:0] ax1_i,
  input  logic signed [COORD_WIDTH-1:0] ay1_i,
  input  logic signed [COORD_WIDTH-1:0] bx0_i,
  input  logic signed [COORD_WIDTH-1:0] by0_i,
  input  logic signed [COORD_WIDTH-1:0] bx1_i,
  input  logic signed [COORD_WIDTH-1:0] by1_i,
  output logic                          rej_o,
  output logic signed [COORD_WIDTH:0]   dxa_o,
  output logic signed [COORD_WIDTH:0]   dya_o,
  output logic signed [COORD_WIDTH:0]   dxb_o,
  output logic signed [COORD_WIDTH:0]   dyb_o,
  output logic signed [COORD_WIDTH:0]   ex_o,
  output logic signed [COORD_WIDTH:0]   ey_o,
  output logic signed [COORD_WIDTH:0]   fx_o,
  output logic signed [COORD_WIDTH:0]   fy_o
);

  localparam int DW = COORD_WIDTH + 1;

  logic                 rej_d, rej_q;
  logic signed [DW-1:0] dxa_d, dya_d, dxb_d, dyb_d, ex_d, ey_d, fx_d, fy_d;
  logic signed [DW-1:0] dxa_q, dya_q, dxb_q, dyb_q, ex_q, ey_q, fx_q, fy_q;

  // Sign-extend one coordinate to the difference width
  function automatic logic signed [DW-1:0] sx(input logic signed [COORD_WIDTH-1:0] v);
    sx = $signed({v[COORD_WIDTH-1], v});
  endfunction

  // Strict box test: A entirely left, right, below or above B
  always_comb begin
    rej_d = (ax0_i > bx0_i && ax1_i > bx0_i && ax0_i > bx1_i && ax1_i > bx1_i) ||
            (ax0_i < bx0_i && ax1_i < bx0_i && ax0_i < bx1_i && ax1_i < bx1_i) ||
            (ay0_i > by0_i && ay1_i > by0_i && ay0_i > by1_i && ay1_i > by1_i) ||
            (ay0_i < by0_i && ay1_i < by0_i && ay0_i < by1_i && ay1_i < by1_i);
  end

  // Direction vectors of A and B, offsets of B's endpoints from A's start
  always_comb begin
    dxa_d = sx(ax1_i) - sx(ax0_i);
    dya_d = sx(ay1_i) - sx(ay0_i);
    dxb_d = sx(bx1_i) - sx(bx0_i);
    dyb_d = sx(by1_i) - sx(by0_i);
    ex_d  = sx(bx0_i) - sx(ax0_i);
    ey_d  = sx(by0_i) - sx(ay0_i);
    fx_d  = sx(bx1_i) - sx(ax0_i);
    fy_d  = sx(by1_i) - sx(ay0_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      rej_q <= rej_d;
      dxa_q <= dxa_d;
      dya_q <= dya_d;
      dxb_q <= dxb_d;
      dyb_q <= dyb_d;
      ex_q  <= ex_d;
      ey_q  <= ey_d;
      fx_q  <= fx_d;
      fy_q  <= fy_d;
    end
  end

  assign rej_o = rej_q;
  assign dxa_o = dxa_q;
  assign dya_o = dya_q;
  assign dxb_o = dxb_q;
  assign dyb_o = dyb_q;
  assign ex_o  = ex_q;
  assign ey_o  = ey_q;
  assign fx_o  = fx_q;
  assign fy_o  = fy_q;

endmodule

// ----- hw/rtl/sit_cross.sv -----
// Stages 2 and 3: partial products, then the four cross products.
module sit_cross #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk_i,
  input  sit_pkg::stage_en_t                en_i,
  input  logic                              rej_i,
  input  logic signed [COORD_WIDTH:0]       dxa_i,
  input  logic signed [COORD_WIDTH:0]       dya_i,
  input  logic signed [COORD_WIDTH:0]       dxb_i,
  input  logic signed [COORD_WIDTH:0]       dyb_i,
  input  logic signed [COORD_WIDTH:0]       ex_i,
  input  logic signed [COORD_WIDTH:0]       ey_i,
  input  logic signed [COORD_WIDTH:0]       fx_i,
  input  logic signed [COORD_WIDTH:0]       fy_i,
  output logic                              rej_o,
  output logic                              xeq_o,
  output logic signed [2*COORD_WIDTH+2:0]   den_o,
  output logic signed [2*COORD_WIDTH+2:0]   tn_o,
  output logic signed [2*COORD_WIDTH+2:0]   un_o,
  output logic signed [2*COORD_WIDTH+2:0]   col_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  // stage 2 registers
  logic                 rej2_q, xeq2_q;
  logic signed [PW-1:0] p_dn_a_q, p_dn_b_q, p_tn_a_q, p_tn_b_q;
  logic signed [PW-1:0] p_un_a_q, p_un_b_q, p_cl_a_q, p_cl_b_q;

  // stage 3 registers
  logic                 rej3_q, xeq3_q;
  logic signed [CW-1:0] den_d, tn_d, un_d, col_d;
  logic signed [CW-1:0] den_q, tn_q, un_q, col_q;

  function automatic logic signed [CW-1:0] ext(input logic signed [PW-1:0] v);
    ext = $signed({v[PW-1], v});
  endfunction

  // Eight independent multiplies, one per pair
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      rej2_q   <= rej_i;
      xeq2_q   <= (dxa_i == '0);
      p_dn_a_q <= PW'(dxa_i * dyb_i);
      p_dn_b_q <= PW'(dya_i * dxb_i);
      p_tn_a_q <= PW'(ex_i * dyb_i);
      p_tn_b_q <= PW'(ey_i * dxb_i);
      p_un_a_q <= PW'(ex_i * dya_i);
      p_un_b_q <= PW'(ey_i * dxa_i);
      p_cl_a_q <= PW'(ex_i * fy_i);
      p_cl_b_q <= PW'(ey_i * fx_i);
    end
  end

  // Cross products: denominator, A's and B's parameter numerators, collinearity
  always_comb begin
    den_d = ext(p_dn_a_q) - ext(p_dn_b_q);
    tn_d  = ext(p_tn_a_q) - ext(p_tn_b_q);
    un_d  = ext(p_un_a_q) - ext(p_un_b_q);
    col_d = ext(p_cl_a_q) - ext(p_cl_b_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      rej3_q <= rej2_q;
      xeq3_q <= xeq2_q;
      den_q  <= den_d;
      tn_q   <= tn_d;
      un_q   <= un_d;
      col_q  <= col_d;
    end
  end

  assign rej_o = rej3_q;
  assign xeq_o = xeq3_q;
  assign den_o = den_q;
  assign tn_o  = tn_q;
  assign un_o  = un_q;
  assign col_o = col_q;

endmodule

// ----- hw/rtl/sit_decide.sv -----
// Stage 4: range tests against the denominator and final verdict.
module sit_decide #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk_i,
  input  sit_pkg::stage_en_t              en_i,
  input  logic                            rej_i,
  input  logic                            xeq_i,
  input  logic signed [2*COORD_WIDTH+2:0] den_i,
  input  logic signed [2*COORD_WIDTH+2:0] tn_i,
  input  logic signed [2*COORD_WIDTH+2:0] un_i,
  input  logic signed [2*COORD_WIDTH+2:0] col_i,
  output logic                            hit_o
);

  logic hit_d, hit_q;
  logic den_zero, den_neg;
  logic t_ok, u_ok;

  // Closed range 0..D for positive D, D..0 for negative D
  always_comb begin
    den_zero = (den_i == '0);
    den_neg  = den_i[2*COORD_WIDTH+2];
    if (den_neg) begin
      t_ok = (tn_i <= 0) && (tn_i >= den_i);
      u_ok = (un_i <= 0) && (un_i >= den_i);
    end else begin
      t_ok = (tn_i >= 0) && (tn_i <= den_i);
      u_ok = (un_i >= 0) && (un_i <= den_i);
    end
    if (rej_i) begin
      hit_d = 1'b0;
    end else if (den_zero) begin
      // reported as a hit when A is vertical or B lies on a line through A's start
      hit_d = xeq_i || (col_i == '0);
    end else begin
      hit_d = t_ok && u_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

// ----- hw/rtl/segment_intersection_test.sv -----
// Segment intersection test: top level with pipeline control.
//
// Tests whether two closed segments A and B with signed integer endpoints
// intersect, using exact integer arithmetic. One word is accepted per cycle
// while the output is not stalled. The four stages are: box rejection and
// differences, the eight partial products, the cross-product subtractions,
// and the range comparison that feeds the output register. The multiplier
// stage, about COORD_WIDTH+1 bits square, sets the clock rate. A stalled
// output holds the pipeline in place; a bubble in any stage is filled
// without waiting for the output side.
`include "assert_macros.svh"

module segment_intersection_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] ax0_i,
  input  logic signed [COORD_WIDTH-1:0] ay0_i,
  input  logic signed [COORD_WIDTH-1:0] ax1_i,
  input  logic signed [COORD_WIDTH-1:0] ay1_i,
  input  logic signed [COORD_WIDTH-1:0] bx0_i,
  input  logic signed [COORD_WIDTH-1:0] by0_i,
  input  logic signed [COORD_WIDTH-1:0] bx1_i,
  input  logic signed [COORD_WIDTH-1:0] by1_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int CW = 2 * DW + 1;

  sit_pkg::stage_en_t en;
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;

  logic                 rej1, rej3, xeq3;
  logic signed [DW-1:0] dxa, dya, dxb, dyb, ex, ey, fx, fy;
  logic signed [CW-1:0] den, tn, un, col;

  // Each stage loads when empty or when its contents move on
  always_comb begin
    en.s4 = !v4_q || out_ready_i;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  assign in_ready_o  = en.s1;
  assign out_valid_o = v4_q;

  // Valid bits follow the data
  always_comb begin
    v1_d = en.s1 ? in_valid_i : v1_q;
    v2_d = en.s2 ? v1_q : v2_q;
    v3_d = en.s3 ? v2_q : v3_q;
    v4_d = en.s4 ? v3_q : v4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  sit_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .ax0_i (ax0_i),
    .ay0_i (ay0_i),
    .ax1_i (ax1_i),
    .ay1_i (ay1_i),
    .bx0_i (bx0_i),
    .by0_i (by0_i),
    .bx1_i (bx1_i),
    .by1_i (by1_i),
    .rej_o (rej1),
    .dxa_o (dxa),
    .dya_o (dya),
    .dxb_o (dxb),
    .dyb_o (dyb),
    .ex_o  (ex),
    .ey_o  (ey),
    .fx_o  (fx),
    .fy_o  (fy)
  );

  sit_cross #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_cross (
    .clk_i (clk_i),
    .en_i  (en),
    .rej_i (rej1),
    .dxa_i (dxa),
    .dya_i (dya),
    .dxb_i (dxb),
    .dyb_i (dyb),
    .ex_i  (ex),
    .ey_i  (ey),
    .fx_i  (fx),
    .fy_i  (fy),
    .rej_o (rej3),
    .xeq_o (xeq3),
    .den_o (den),
    .tn_o  (tn),
    .un_o  (un),
    .col_o (col)
  );

  sit_decide #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_decide (
    .clk_i (clk_i),
    .en_i  (en),
    .rej_i (rej3),
    .xeq_i (xeq3),
    .den_i (den),
    .tn_i  (tn),
    .un_i  (un),
    .col_i (col),
    .hit_o (hit_o)
  );

  // An empty first stage always takes a word
  `ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !v1_q, in_ready_o)
  // An accepted word occupies the first stage next cycle
  `ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_valid_i && in_ready_o, v1_q)
  // A box-rejected pair moving to the output reports no hit
  `ASSERT_NEXT(a_reject_no_hit, clk_i, rst_ni, v3_q && rej3 && en.s4,
               out_valid_o && !hit_o)
  // Output register never loads while holding an untaken result
  `ASSERT_IMPLY(a_hold_output, clk_i, rst_ni, v4_q && !out_ready_i, !en.s4)

endmodule
